// ----- src/aeu_pkg.sv -----
package aeu_pkg;

    // Default buffer depth of the feedback delay
    localparam int AEU_MAX_DELAY = 32768;

    // APB address width: three 32-bit registers at byte addresses 0, 4, 8
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_GAIN   = 2'd1;
    localparam logic [1:0] REG_LENGTH = 2'd2;

    // Reset values
    localparam logic [15:0] GAIN_ONE     = 16'd32768;
    localparam logic [15:0] LENGTH_RESET = 16'd1;

    localparam logic signed [15:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

    typedef enum logic [1:0] {
        MODE_LOWPASS  = 2'd0,
        MODE_HIGHPASS = 2'd1,
        MODE_DISTORT  = 2'd2,
        MODE_DELAY    = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode       mode;
        logic [15:0] gain;
        logic [15:0] length;
    } t_cfg;

    // round(32767 * tanh(i/8)) for i = 0..64; larger indexes hold full scale
    function automatic logic [14:0] f_tanh(input logic [6:0] idx);
        logic [14:0] v;
        case (idx)
            7'd0:  v = 15'd0;
            7'd1:  v = 15'd4075;
            7'd2:  v = 15'd8025;
            7'd3:  v = 15'd11742;
            7'd4:  v = 15'd15142;
            7'd5:  v = 15'd18173;
            7'd6:  v = 15'd20812;
            7'd7:  v = 15'd23065;
            7'd8:  v = 15'd24955;
            7'd9:  v = 15'd26518;
            7'd10: v = 15'd27796;
            7'd11: v = 15'd28829;
            7'd12: v = 15'd29659;
            7'd13: v = 15'd30321;
            7'd14: v = 15'd30846;
            7'd15: v = 15'd31261;
            7'd16: v = 15'd31588;
            7'd17: v = 15'd31845;
            7'd18: v = 15'd32047;
            7'd19: v = 15'd32205;
            7'd20: v = 15'd32328;
            7'd21: v = 15'd32425;
            7'd22: v = 15'd32500;
            7'd23: v = 15'd32559;
            7'd24: v = 15'd32605;
            7'd25: v = 15'd32641;
            7'd26: v = 15'd32669;
            7'd27: v = 15'd32690;
            7'd28: v = 15'd32707;
            7'd29: v = 15'd32720;
            7'd30: v = 15'd32731;
            7'd31: v = 15'd32739;
            7'd32: v = 15'd32745;
            7'd33: v = 15'd32750;
            7'd34: v = 15'd32754;
            7'd35: v = 15'd32757;
            7'd36: v = 15'd32759;
            7'd37: v = 15'd32761;
            7'd38: v = 15'd32762;
            7'd39: v = 15'd32763;
            7'd40: v = 15'd32764;
            7'd41: v = 15'd32765;
            7'd42: v = 15'd32765;
            7'd43: v = 15'd32766;
            7'd44: v = 15'd32766;
            7'd45: v = 15'd32766;
            7'd46: v = 15'd32766;
            7'd47: v = 15'd32766;
            default: v = 15'd32767;
        endcase
        return v;
    endfunction

    // v / 2^sh truncated toward zero, then clamped to the signed 16-bit range
    function automatic logic signed [15:0] f_trunc_sat16(input logic signed [39:0] v,
                                                         input logic [3:0] sh);
        logic signed [39:0] bias;
        logic signed [39:0] t;
        bias = v[39] ? ((40'sd1 <<< sh) - 40'sd1) : 40'sd0;
        t    = (v + bias) >>> sh;
        if (t > 40'(SAMPLE_MAX)) begin
            return SAMPLE_MAX;
        end else if (t < 40'(SAMPLE_MIN)) begin
            return SAMPLE_MIN;
        end
        return t[15:0];
    endfunction

endpackage

// ----- src/aeu_apb_regs.sv -----
module aeu_apb_regs import aeu_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic       w_wr;
    logic [1:0] w_idx;
    t_cfg       r_cfg;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[PADDR_W-1:2];

    // Register writes; an index past the last register is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode   <= MODE_LOWPASS;
            r_cfg.gain   <= GAIN_ONE;
            r_cfg.length <= LENGTH_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_MODE:   r_cfg.mode   <= t_mode'(pwdata[1:0]);
                REG_GAIN:   r_cfg.gain   <= pwdata[15:0];
                REG_LENGTH: r_cfg.length <= pwdata[15:0];
                default:    r_cfg        <= r_cfg;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (w_idx)
            REG_MODE:   prdata = {30'd0, r_cfg.mode};
            REG_GAIN:   prdata = {16'd0, r_cfg.gain};
            REG_LENGTH: prdata = {16'd0, r_cfg.length};
            default:    prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- src/aeu_delay_ram.sv -----
module aeu_delay_ram import aeu_pkg::*; #(
    parameter int DEPTH = AEU_MAX_DELAY,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = 24
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/audio_effect_unit_top.sv -----
// Pipeline: each sample passes stage A, stage B and the output register in turn.
// A new sample is taken only while stage A is empty, set by the read-modify-write of
// the delay memory (read and single multiplier pass in stage A, write-back and
// filter state update in stage B). A stalled output holds the next sample.
// Reset: synchronous, active low; filter state, position and handshakes clear at
// once. The delay memory is not swept: a fill count marks written entries.
module audio_effect_unit_top import aeu_pkg::*; #(
    parameter int MAX_DELAY = AEU_MAX_DELAY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input stream
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [15:0]        s_axis_tdata,   // [15:0] sample_in
    // output stream
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [15:0]        m_axis_tdata,   // [15:0] sample_out
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int AW = $clog2(MAX_DELAY);
    localparam int LW = $clog2(MAX_DELAY + 1);

    localparam logic signed [36:0] HP_MAX = 37'sh0_FFFF_FFFF;
    localparam logic signed [36:0] HP_MIN = -37'sh1_0000_0000;
    localparam logic signed [36:0] DL_MAX = 37'sh7F_FFFF;
    localparam logic signed [36:0] DL_MIN = -37'sh80_0000;

    t_cfg w_cfg;

    aeu_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // ---------------------------------------------------------------
    // Effect state
    logic signed [31:0] r_lp;
    logic signed [32:0] r_hp;
    logic signed [15:0] r_xp;
    logic [AW-1:0]      r_pos;
    logic [LW-1:0]      r_fill;
    logic [23:0]        r_last_wr;

    // Stage A: memory read in flight, operands and multiply
    logic               r_a_valid;
    t_mode              r_a_mode;
    logic signed [15:0] r_a_x;
    logic [15:0]        r_a_gain;
    logic [AW-1:0]      r_a_addr;
    logic               r_a_hit;
    logic               r_a_fwd;

    // Stage B: rounding, state update, write-back
    logic               r_b_valid;
    t_mode              r_b_mode;
    logic signed [15:0] r_b_x;
    logic [AW-1:0]      r_b_addr;
    logic signed [50:0] r_b_prod;
    logic [14:0]        r_b_tval;
    logic               r_b_dsat;
    logic               r_b_neg;

    // Output register
    logic               r_out_valid;
    logic signed [15:0] r_out_data;

    logic s_fire;
    logic b_fire;
    logic b_write;

    // ---------------------------------------------------------------
    // Handshake
    assign b_fire        = r_b_valid & (~r_out_valid | m_axis_tready);
    assign s_axis_tready = ~r_a_valid & (~r_b_valid | b_fire);
    assign s_fire        = s_axis_tvalid & s_axis_tready;
    assign b_write       = b_fire & (r_b_mode == MODE_DELAY);

    // ---------------------------------------------------------------
    // Buffer length and position in use
    logic [16:0]   w_len17;
    logic [LW-1:0] w_len;
    logic [AW-1:0] w_pos_eff;
    logic [LW-1:0] w_pos_inc;
    logic [AW-1:0] n_pos;
    logic [LW-1:0] n_fill;

    always_comb begin
        if (w_cfg.length == 16'd0) begin
            w_len17 = 17'd1;
        end else if ({1'b0, w_cfg.length} > 17'(MAX_DELAY)) begin
            w_len17 = 17'(MAX_DELAY);
        end else begin
            w_len17 = {1'b0, w_cfg.length};
        end
        w_len     = w_len17[LW-1:0];
        w_pos_eff = (LW'(r_pos) >= w_len) ? '0 : r_pos;
        // advance from the address just read
        w_pos_inc = LW'(r_a_addr) + LW'(1);
        n_pos     = (w_pos_inc >= w_len) ? '0 : w_pos_inc[AW-1:0];
        n_fill    = (w_pos_inc > r_fill) ? w_pos_inc : r_fill;
    end

    // ---------------------------------------------------------------
    // Delay memory
    logic [23:0] w_rdata;
    logic [23:0] w_wdata;

    aeu_delay_ram #(
        .DEPTH (MAX_DELAY),
        .AW    (AW),
        .DW    (24)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (b_write),
        .i_waddr (r_b_addr),
        .i_wdata (w_wdata),
        .i_re    (s_fire & (w_cfg.mode == MODE_DELAY)),
        .i_raddr (w_pos_eff),
        .o_rdata (w_rdata)
    );

    // ---------------------------------------------------------------
    // Stage A: operand select and the shared multiplier
    logic signed [23:0] w_e;
    logic signed [23:0] w_x8;
    logic signed [16:0] w_diff;
    logic signed [16:0] w_xs;
    logic [15:0]        w_abs;
    logic [14:0]        w_t0;
    logic [14:0]        w_t1;
    logic [14:0]        w_dt;
    logic signed [33:0] w_op_a;
    logic signed [16:0] w_op_b;
    logic signed [50:0] w_prod;

    always_comb begin
        w_e    = r_a_fwd ? r_last_wr : (r_a_hit ? w_rdata : 24'd0);
        w_x8   = {r_a_x, 8'd0};
        w_diff = 17'(r_a_x) - 17'(r_xp);
        w_xs   = 17'(r_a_x);
        w_abs  = r_a_x[15] ? 16'(-w_xs) : r_a_x;
        w_t0   = f_tanh(w_abs[15:9]);
        w_t1   = f_tanh(w_abs[15:9] + 7'd1);
        w_dt   = w_t1 - w_t0;
        w_op_b = {1'b0, r_a_gain};
        case (r_a_mode)
            MODE_LOWPASS:  w_op_a = 34'($signed({r_a_x, 15'd0})) - 34'(r_lp);
            MODE_HIGHPASS: w_op_a = 34'(r_hp) + 34'($signed({w_diff, 15'd0}));
            MODE_DISTORT: begin
                w_op_a = {19'd0, w_dt};
                w_op_b = {8'd0, w_abs[8:0]};
            end
            MODE_DELAY:    w_op_a = 34'(w_e) - 34'(w_x8);
            default:       w_op_a = '0;
        endcase
        w_prod = 51'(w_op_a) * 51'(w_op_b);
    end

    // ---------------------------------------------------------------
    // Stage B: rounding and saturation
    logic signed [23:0] w_b_x8;
    logic signed [51:0] w_base;
    logic signed [51:0] w_sum;
    logic signed [36:0] w_q;
    logic signed [31:0] w_lp_new;
    logic signed [32:0] w_hp_new;
    logic signed [23:0] w_dl_new;
    logic [12:0]        w_inc;
    logic [15:0]        w_dmag;
    logic signed [15:0] w_result;

    always_comb begin
        w_b_x8 = {r_b_x, 8'd0};
        case (r_b_mode)
            MODE_LOWPASS: w_base = {{5{r_lp[31]}}, r_lp, 15'd0};
            MODE_DELAY:   w_base = {{13{w_b_x8[23]}}, w_b_x8, 15'd0};
            default:      w_base = '0;
        endcase
        w_sum    = w_base + 52'(r_b_prod) + 52'sd16384;
        w_q      = w_sum[51:15];
        w_lp_new = w_q[31:0];

        if (w_q > HP_MAX) begin
            w_hp_new = HP_MAX[32:0];
        end else if (w_q < HP_MIN) begin
            w_hp_new = HP_MIN[32:0];
        end else begin
            w_hp_new = w_q[32:0];
        end

        if (w_q > DL_MAX) begin
            w_dl_new = DL_MAX[23:0];
        end else if (w_q < DL_MIN) begin
            w_dl_new = DL_MIN[23:0];
        end else begin
            w_dl_new = w_q[23:0];
        end

        // distortion: interpolate between table points, mirror for negative input
        w_inc  = 13'((r_b_prod[21:0] + 22'd256) >> 9);
        w_dmag = r_b_dsat ? 16'(SAMPLE_MAX) : (16'(r_b_tval) + 16'(w_inc));

        case (r_b_mode)
            MODE_LOWPASS:  w_result = f_trunc_sat16(40'(w_lp_new), 4'd15);
            MODE_HIGHPASS: w_result = f_trunc_sat16(40'(w_hp_new), 4'd15);
            MODE_DISTORT:  w_result = r_b_neg ? -$signed(w_dmag) : $signed(w_dmag);
            MODE_DELAY:    w_result = f_trunc_sat16(40'(w_dl_new), 4'd8);
            default:       w_result = '0;
        endcase
    end

    assign w_wdata = w_dl_new;

    // ---------------------------------------------------------------
    // Pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_a_valid <= s_fire;
            r_b_valid <= r_a_valid | (r_b_valid & ~b_fire);
            if (b_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_a_mode <= w_cfg.mode;
            r_a_x    <= $signed(s_axis_tdata);
            r_a_gain <= (w_cfg.gain > GAIN_ONE) ? GAIN_ONE : w_cfg.gain;
            r_a_addr <= w_pos_eff;
            r_a_hit  <= (LW'(w_pos_eff) < r_fill);
            // same entry written back at this edge: take it from the write register
            r_a_fwd  <= b_write & (r_b_addr == w_pos_eff);
        end
        if (r_a_valid) begin
            r_b_mode <= r_a_mode;
            r_b_x    <= r_a_x;
            r_b_addr <= r_a_addr;
            r_b_prod <= w_prod;
            r_b_tval <= w_t0;
            r_b_dsat <= w_abs[15];
            r_b_neg  <= r_a_x[15];
        end
        if (b_write) begin
            r_last_wr <= w_wdata;
        end
        if (b_fire) begin
            r_out_data <= w_result;
        end
    end

    // Effect state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp   <= '0;
            r_hp   <= '0;
            r_xp   <= '0;
            r_pos  <= '0;
            r_fill <= '0;
        end else begin
            if (r_a_valid && r_a_mode == MODE_DELAY) begin
                r_pos  <= n_pos;
                r_fill <= n_fill;
            end
            if (b_fire) begin
                case (r_b_mode)
                    MODE_LOWPASS: r_lp <= w_lp_new;
                    MODE_HIGHPASS: begin
                        r_hp <= w_hp_new;
                        r_xp <= r_b_x;
                    end
                    default: r_lp <= r_lp;
                endcase
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // ---------------------------------------------------------------
    // Assertions
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid |-> !s_axis_tready)
        else $error("input taken while stage A busy");

    a_a_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid |=> r_b_valid)
        else $error("stage A item lost");

    a_b_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && !b_fire) |=> (r_b_valid && $stable(r_b_prod)))
        else $error("stalled stage B item changed");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= LW'(MAX_DELAY)) && (LW'(r_pos) < LW'(MAX_DELAY)))
        else $error("delay fill count or position out of range");

    a_fwd_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_a_fwd) |-> r_a_hit)
        else $error("forwarded entry not marked written");

endmodule

// ----- verif/audio_effect_unit_top_test.sv -----
`timescale 1ns / 1ps

module audio_effect_unit_top_test import aeu_pkg::*;;

    localparam int     STALL_LIMIT = 2000;
    localparam int     PHASES      = 12;
    localparam int     PHASE_ITEMS = 118;
    localparam longint HP_MAX      = (64'sd1 <<< 32) - 1;
    localparam longint DLY_MAX     = (64'sd1 <<< 23) - 1;
    // no register lives at this index; writes there must be dropped
    localparam logic [1:0] REG_NONE = 2'd3;

    logic               i_clk;
    logic               i_rst_n       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [15:0]        s_axis_tdata  = '0;   // [15:0] sample_in
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [15:0]        m_axis_tdata;         // [15:0] sample_out
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [PADDR_W-1:0] paddr         = '0;
    logic [PDATA_W-1:0] pwdata        = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    audio_effect_unit_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Shadow of the register file and of the effect state
    t_mode       cfg_mode   = MODE_LOWPASS;
    logic [15:0] cfg_gain   = GAIN_ONE;
    logic [15:0] cfg_length = LENGTH_RESET;
    longint      lp_acc     = 0;
    longint      hp_acc     = 0;
    longint      hp_prev    = 0;
    int          dly_mem [AEU_MAX_DELAY];
    int unsigned dly_pos    = 0;

    // round(32767 * tanh(i/8)), knots of the soft-clip curve
    int shaper_lut [65] = '{
        0, 4075, 8025, 11742, 15142, 18173, 20812, 23065,
        24955, 26518, 27796, 28829, 29659, 30321, 30846, 31261,
        31588, 31845, 32047, 32205, 32328, 32425, 32500, 32559,
        32605, 32641, 32669, 32690, 32707, 32720, 32731, 32739,
        32745, 32750, 32754, 32757, 32759, 32761, 32762, 32763,
        32764, 32765, 32765, 32766, 32766, 32766, 32766, 32766,
        32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
        32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
        32767
    };

    logic [15:0] expected_out [$];
    logic [15:0] want;
    int          fails        = 0;
    int          items_sent   = 0;
    int          results_seen = 0;
    int          reg_writes   = 0;
    int          quiet_cycles = 0;
    int          hold_cnt     = 0;
    bit          steady       = 1'b0;

    // Directed stimulus: register write or sample, with a literal result where obvious
    typedef struct packed {
        bit          is_write;
        logic [1:0]  reg_idx;
        logic [31:0] wdata;
        logic [15:0] smp;
        bit          known;
        logic [15:0] outv;
    } t_step;

    localparam int DIR_ROWS = 39;
    t_step dir_steps [DIR_ROWS] = '{
        // low-pass at unity gain follows the input exactly; then at half gain
        '{1'b0, REG_MODE, 32'd0, SAMPLE_MAX, 1'b1, SAMPLE_MAX},
        '{1'b0, REG_MODE, 32'd0, SAMPLE_MIN, 1'b1, SAMPLE_MIN},
        '{1'b0, REG_MODE, 32'd0, 16'd0, 1'b1, 16'd0},
        '{1'b1, REG_GAIN, 32'd16384, 16'd0, 1'b0, 16'd0},
        '{1'b0, REG_MODE, 32'd0, 16'd12345, 1'b0, 16'd0},
        '{1'b0, REG_MODE, 32'd0, 16'hffff, 1'b0, 16'd0},
        // high-pass at unity gain, full-scale step both ways, then just below unity gain
        '{1'b1, REG_MODE, 32'(MODE_HIGHPASS), 16'd0, 1'b0, 16'd0},
        '{1'b1, REG_GAIN, 32'd32768, 16'd0, 1'b0, 16'd0},
        '{1'b0, REG_MODE, 32'd0, SAMPLE_MAX, 1'b1, SAMPLE_MAX},
        '{1'b0, REG_MODE, 32'd0, SAMPLE_MIN, 1'b1, SAMPLE_MIN},
        '{1'b1, REG_GAIN, 32'd32700, 16'd0, 1'b0, 16'd0},
        '{1'b0, REG_MODE, 32'd0, SAMPLE_MAX, 1'b0, 16'd0},
        '{1'b0, REG_MODE, 32'd0, SAMPLE_MIN, 1'b0, 16'd0},
        '{1'b0, REG_MODE, 32'd0, SAMPLE_MAX, 1'b0, 16'd0},
        '{1'b0, REG_MODE, 32'd0, SAMPLE_MIN, 1'b0, 16'd0},
        // distortion, selected with junk in the upper bits of the write
        '{1'b1, REG_MODE, 32'hffff_fff4 | 32'(MODE_DISTORT), 16'd0, 1'b0, 16'd0},
        '{1'b0, REG_MODE, 32'd0, SAMPLE_MAX, 1'b1, SAMPLE_MAX},
        '{1'b0, REG_MODE, 32'd0, SAMPLE_MIN, 1'b1, 16'sh8001},  // clips to -32767
        '{1'b0, REG_MODE, 32'd0, 16'd0, 1'b1, 16'd0},
        '{1'b0, REG_MODE, 32'd0, 16'd512, 1'b1, 16'd4075},     // first knot
        '{1'b0, REG_MODE, 32'd0, 16'hffff, 1'b0, 16'd0},
        // delay: gain above one, zero length, then half gain at length 5
        '{1'b1, REG_GAIN, 32'hffff_ffff, 16'd0, 1'b0, 16'd0},
        '{1'b1, REG_MODE, 32'(MODE_DELAY), 16'd0, 1'b0, 16'd0},
        '{1'b1, REG_LENGTH, 32'd0, 16'd0, 1'b0, 16'd0},
        '{1'b0, REG_MODE, 32'd0, 16'd1000, 1'b1, 16'd0},       // pure feedback of an empty slot
        '{1'b1, REG_GAIN, 32'd0, 16'd0, 1'b0, 16'd0},
        '{1'b0, REG_MODE, 32'd0, SAMPLE_MIN, 1'b1, SAMPLE_MIN},  // dry path only
        '{1'b1, REG_GAIN, 32'd16384, 16'd0, 1'b0, 16'd0},
        '{1'b1, REG_LENGTH, 32'd5, 16'd0, 1'b0, 16'd0},
        '{1'b0, REG_MODE, 32'd0, 16'd20000, 1'b0, 16'd0},
        '{1'b0, REG_MODE, 32'd0, -16'sd20000, 1'b0, 16'd0},
        '{1'b0, REG_MODE, 32'd0, 16'd7, 1'b0, 16'd0},
        // shrink below the current position
        '{1'b1, REG_LENGTH, 32'd2, 16'd0, 1'b0, 16'd0},
        '{1'b0, REG_MODE, 32'd0, 16'd100, 1'b0, 16'd0},
        '{1'b0, REG_MODE, 32'd0, -16'sd100, 1'b0, 16'd0},
        // oversized length, then a write to a missing register
        '{1'b1, REG_LENGTH, 32'd40000, 16'd0, 1'b0, 16'd0},
        '{1'b0, REG_MODE, 32'd0, SAMPLE_MAX, 1'b0, 16'd0},
        '{1'b1, REG_NONE, 32'd2, 16'd0, 1'b0, 16'd0},
        '{1'b0, REG_MODE, 32'd0, -16'sd5, 1'b0, 16'd0}
    };

    function automatic longint round_q15(longint v);
        return (v + 16384) >>> 15;
    endfunction

    // Advance the effect state by one sample and return the output sample
    function automatic logic [15:0] process_sample(logic [15:0] smp);
        longint      x, g, acc, x8, mag, frac;
        int unsigned len, idx;
        int          shift;
        x = longint'($signed(smp));
        g = (cfg_gain > GAIN_ONE) ? 64'sd32768 : longint'(cfg_gain);
        shift = 15;
        case (cfg_mode)
            MODE_LOWPASS: begin
                lp_acc = lp_acc + round_q15(g * (x * 32768 - lp_acc));
                acc = lp_acc;
            end
            MODE_HIGHPASS: begin
                acc = round_q15(g * (hp_acc + (x - hp_prev) * 32768));
                if (acc > HP_MAX) begin
                    acc = HP_MAX;
                end else if (acc < -HP_MAX - 1) begin
                    acc = -HP_MAX - 1;
                end
                hp_acc = acc;
                hp_prev = x;
            end
            MODE_DISTORT: begin
                mag = (x < 0) ? -x : x;
                idx = int'(mag >>> 9);
                frac = mag & 511;
                if (idx >= 64) begin
                    acc = shaper_lut[64];
                end else begin
                    acc = shaper_lut[idx] +
                          (((shaper_lut[idx + 1] - shaper_lut[idx]) * frac + 256) >>> 9);
                end
                if (x < 0) begin
                    acc = -acc;
                end
                shift = 0;
            end
            default: begin
                // delay: length clamped to 1..depth, stale position wraps first
                len = (cfg_length == 0) ? 1 :
                      ((cfg_length > AEU_MAX_DELAY) ? AEU_MAX_DELAY : cfg_length);
                if (dly_pos >= len) begin
                    dly_pos = 0;
                end
                x8 = x * 256;
                acc = x8 + round_q15(g * (longint'(dly_mem[dly_pos]) - x8));
                if (acc > DLY_MAX) begin
                    acc = DLY_MAX;
                end else if (acc < -DLY_MAX - 1) begin
                    acc = -DLY_MAX - 1;
                end
                dly_mem[dly_pos] = int'(acc);
                dly_pos = (dly_pos + 1 >= len) ? 0 : dly_pos + 1;
                shift = 8;
            end
        endcase
        // scale down toward zero, then clamp to 16 bits
        acc = (acc >= 0) ? (acc >>> shift) : -((-acc) >>> shift);
        if (acc > 32767) begin
            acc = 32767;
        end else if (acc < -32768) begin
            acc = -32768;
        end
        return acc[15:0];
    endfunction

    // One sample transaction on the input stream, with an optional gap first
    task automatic play_sample(logic [15:0] smp, bit known, logic [15:0] outv);
        logic [15:0] out;
        if (!steady && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        do @(posedge i_clk); while (!s_axis_tready);
        out = process_sample(smp);
        expected_out.push_back(known ? outv : out);
        items_sent++;
    endtask

    // Stop sending and let every pending sample come out
    task automatic await_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_out.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Register write followed by a read back of the same address
    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        logic [31:0] held;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_MODE:   cfg_mode = t_mode'(val[1:0]);
            REG_GAIN:   cfg_gain = val[15:0];
            REG_LENGTH: cfg_length = val[15:0];
            default: ;
        endcase
        reg_writes++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_MODE:   held = 32'(cfg_mode);
            REG_GAIN:   held = 32'(cfg_gain);
            REG_LENGTH: held = 32'(cfg_length);
            default:    held = '0;
        endcase
        if (idx != REG_NONE && prdata !== held) begin
            $error("prdata[%0d]: expected %0d, got %0d", idx, held, prdata);
            fails++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Output side: check each transaction, stall in random bursts
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_out.size() == 0) begin
                $error("sample_out: expected nothing, got %0d", $signed(m_axis_tdata));
                fails++;
            end else begin
                want = expected_out.pop_front();
                if (m_axis_tdata !== want) begin
                    $error("sample_out: expected %0d, got %0d",
                           $signed(want), $signed(m_axis_tdata));
                    fails++;
                end
                results_seen++;
            end
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end else if (!steady && $urandom_range(0, 9) == 0) begin
            hold_cnt = $urandom_range(0, 11);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus
    initial begin
        logic [15:0] gain;
        logic [15:0] length;
        logic [15:0] smp;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_steps[r].is_write) begin
                await_idle();
                reg_write(dir_steps[r].reg_idx, dir_steps[r].wdata);
            end else begin
                play_sample(dir_steps[r].smp, dir_steps[r].known, dir_steps[r].outv);
            end
        end

        // random phases, each effect several times with a fresh setting
        for (int ph = 0; ph < PHASES; ph++) begin
            await_idle();
            steady = (ph % 3 == 2) || (ph == PHASES - 1);
            case ($urandom_range(0, 4))
                0:       gain = GAIN_ONE;
                1:       gain = 16'd0;
                2:       gain = 16'($urandom_range(32769, 65535));
                3:       gain = 16'($urandom_range(28000, 32767));
                default: gain = 16'($urandom_range(1, 32767));
            endcase
            case (ph)
                3:       length = 16'($urandom_range(1, 16));
                7:       length = 16'(AEU_MAX_DELAY);
                11:      length = 16'($urandom_range(1, 300));
                default: length = 16'($urandom);
            endcase
            reg_write(REG_MODE, ($urandom() & 32'hffff_fffc) | 32'(t_mode'(ph % 4)));
            reg_write(REG_GAIN, {16'($urandom), gain});
            reg_write(REG_LENGTH, {16'($urandom), length});
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 5) == 0) begin
                    case ($urandom_range(0, 4))
                        0:       smp = SAMPLE_MAX;
                        1:       smp = SAMPLE_MIN;
                        2:       smp = 16'd0;
                        3:       smp = 16'hffff;
                        default: smp = 16'd1;
                    endcase
                end else begin
                    smp = 16'($urandom);
                end
                play_sample(smp, 1'b0, 16'd0);
            end
        end

        await_idle();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d samples (%0d outputs checked) across all four effects,",
                 items_sent, results_seen);
        $display("with %0d register writes including gain, length and address corner values.",
                 reg_writes);
        if (fails == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
